FILE: hdl/cdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_pkg
// Types, command codes and calendar helpers for the calendar date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DayW-1:0]   DayReset   = 5'd1;
  localparam logic [MonthW-1:0] MonthReset = 4'd1;
  localparam logic [YearW-1:0]  YearReset  = 16'd2000;

  localparam logic [MonthW-1:0] MonthLast = 4'd12;
  localparam logic [DayW-1:0]   DayLast   = 5'd31;
  localparam logic [YearW-1:0]  YearMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_INC  = 2'd1,
    CMD_DEC  = 2'd2,
    CMD_CMP  = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEFAULT_DAY   = 2'd0,
    CFG_DEFAULT_MONTH = 2'd1,
    CFG_DEFAULT_YEAR  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    cmd_t              command;
    logic [DayW-1:0]   in_day;
    logic [MonthW-1:0] in_month;
    logic [YearW-1:0]  in_year;
  } in_item_t;

  typedef struct packed {
    logic [DayW-1:0]   out_day;
    logic [MonthW-1:0] out_month;
    logic [YearW-1:0]  out_year;
    logic              bad_date;
    logic              is_earlier;
  } out_item_t;

  // Days in a month, zero for a code outside 1..12; leap every fourth year.
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] month,
                                                   input logic [YearW-1:0]  year);
    logic [DayW-1:0] len;
    case (month) inside
      4'd2:                               len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:            len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                            len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/cdc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_step
// Next-date logic: resolves defaults, then loads, steps or compares a date.
// ----------------------------------------------------------------------------
module cdc_step (
  input  cdc_pkg::in_item_t item,
  input  cdc_pkg::date_t    cur,
  input  cdc_pkg::date_t    dflt,
  output cdc_pkg::date_t    nxt,
  output logic              bad_date,
  output logic              is_earlier
);
  import cdc_pkg::*;

  date_t           arg;
  logic [DayW-1:0] cur_len;
  logic [DayW-1:0] arg_len;
  logic [DayW-1:0] prev_len;
  logic [MonthW-1:0] prev_month;

  // Zero fields take the default registers
  always_comb begin
    arg.day   = (item.in_day   == '0) ? dflt.day   : item.in_day;
    arg.month = (item.in_month == '0) ? dflt.month : item.in_month;
    arg.year  = (item.in_year  == '0) ? dflt.year  : item.in_year;
  end

  assign prev_month = cur.month - 4'd1;
  assign cur_len    = month_length(cur.month, cur.year);
  assign arg_len    = month_length(arg.month, arg.year);
  assign prev_len   = month_length(prev_month, cur.year);

  always_comb begin
    nxt        = cur;
    bad_date   = 1'b0;
    is_earlier = 1'b0;
    case (item.command)
      CMD_LOAD: begin
        if (arg_len == '0 || arg.day == '0 || arg.day > arg_len) begin
          bad_date = 1'b1;
        end else begin
          nxt = arg;
        end
      end
      CMD_INC: begin
        if (cur.day < cur_len) begin
          nxt.day = cur.day + 5'd1;
        end else if (cur.month >= MonthLast) begin
          if (cur.year == YearMax) begin
            bad_date = 1'b1;
          end else begin
            nxt.year  = cur.year + 16'd1;
            nxt.month = 4'd1;
            nxt.day   = 5'd1;
          end
        end else begin
          nxt.month = cur.month + 4'd1;
          nxt.day   = 5'd1;
        end
      end
      CMD_DEC: begin
        if (cur.day > 5'd1) begin
          nxt.day = cur.day - 5'd1;
        end else if (cur.month <= 4'd1) begin
          if (cur.year == '0) begin
            bad_date = 1'b1;
          end else begin
            nxt.year  = cur.year - 16'd1;
            nxt.month = MonthLast;
            nxt.day   = DayLast;
          end
        end else begin
          nxt.month = prev_month;
          nxt.day   = prev_len;
        end
      end
      CMD_CMP: begin
        // Year first, then month, then day
        is_earlier = (cur.year < arg.year) ||
                     (cur.year == arg.year && (cur.month < arg.month ||
                      (cur.month == arg.month && cur.day < arg.day)));
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: hdl/calendar_date_up_down_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_up_down_counter
// Holds one calendar date and runs one load, step or compare command per item.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_stall    | in_data  (command, day, month, year)
//  out     | out_valid / out_stall  | out_data (date, bad_date, is_earlier)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (default date)
//
//  One item per cycle sustained while the result side is not stalled.
//  An item sits in the input register, then the next-date logic updates the
//  stored date and fills the result register at the same edge.
//  Reset (rst, synchronous) sets the date and the defaults to 1 Jan 2000.
//  out_stall holds the result register; in_stall rises only while both
//  registers are full and the result is stalled. cfg_ready is always high.
// ----------------------------------------------------------------------------
module calendar_date_up_down_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cdc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cdc_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cdc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [cdc_pkg::CfgDataW-1:0]        cfg_data
);
  import cdc_pkg::*;

  logic      in_full;
  in_item_t  in_q;
  date_t     date;
  date_t     date_next;
  date_t     dflt;
  logic      step_bad;
  logic      step_earlier;
  logic      out_free;
  logic      advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_full && out_free;
  assign in_stall  = in_full && !out_free;

  cdc_step u_step (
    .item       (in_q),
    .cur        (date),
    .dflt       (dflt),
    .nxt        (date_next),
    .bad_date   (step_bad),
    .is_earlier (step_earlier)
  );

  // Default date registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt.day   <= DayReset;
      dflt.month <= MonthReset;
      dflt.year  <= YearReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEFAULT_DAY:   dflt.day   <= cfg_data[DayW-1:0];
        CFG_DEFAULT_MONTH: dflt.month <= cfg_data[MonthW-1:0];
        CFG_DEFAULT_YEAR:  dflt.year  <= cfg_data[YearW-1:0];
        default:           dflt       <= dflt;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Stored date advances with each item that moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      date.day   <= DayReset;
      date.month <= MonthReset;
      date.year  <= YearReset;
    end else if (advance) begin
      date <= date_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_day    <= date_next.day;
      out_data.out_month  <= date_next.month;
      out_data.out_year   <= date_next.year;
      out_data.bad_date   <= step_bad;
      out_data.is_earlier <= step_earlier;
    end
  end

`ifndef SYNTHESIS
  a_bad_holds_date: assert property (@(posedge clk) disable iff (rst)
    (advance && step_bad) |=> (date == $past(date)))
    else $error("date changed on a rejected command");

  a_result_date_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_month >= 4'd1 && out_data.out_month <= MonthLast &&
                   out_data.out_day != '0))
    else $error("result holds an impossible date");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.bad_date && out_data.is_earlier))
    else $error("bad_date and is_earlier both set");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the calendar date up/down counter.
// A queue-fed driver sends load, step and compare commands with random gaps.
// A monitor stalls the result side at random and checks each result against
// a date predictor that tracks the stored date and the default-date registers.
// The defaults are rewritten between phases, extremes and out-of-range values
// among them.
// ----------------------------------------------------------------------------
module testbench;
  import cdc_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseCount = 7;
  localparam int PhaseItems = 166;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state and default-date registers
  logic [DayW-1:0]   cur_day   = DayReset;
  logic [MonthW-1:0] cur_month = MonthReset;
  logic [YearW-1:0]  cur_year  = YearReset;
  logic [DayW-1:0]   dflt_day   = DayReset;
  logic [MonthW-1:0] dflt_month = MonthReset;
  logic [YearW-1:0]  dflt_year  = YearReset;

  in_item_t  pending_cmds[$];
  out_item_t expected_dates[$];

  bit quiet = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int items_queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int cfg_writes = 0;
  int n_load = 0, n_inc = 0, n_dec = 0, n_cmp = 0;
  int n_bad = 0, n_earlier = 0;

  calendar_date_up_down_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [DayW-1:0] days_in_month(logic [MonthW-1:0] mon,
                                                    logic [YearW-1:0] yr);
    case (mon)
      4'd2:                                       return (yr % 4 == 0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      default:                                    return 5'd0;
    endcase
  endfunction

  // Apply one command to the tracked date and return the result it gives.
  function automatic out_item_t date_after_command(in_item_t item);
    logic [DayW-1:0]   d;
    logic [DayW-1:0]   len;
    logic [MonthW-1:0] m;
    logic [YearW-1:0]  y;
    out_item_t res;
    d = (item.in_day == '0) ? dflt_day : item.in_day;
    m = (item.in_month == '0) ? dflt_month : item.in_month;
    y = (item.in_year == '0) ? dflt_year : item.in_year;
    res = '0;
    case (item.command)
      CMD_LOAD: begin
        len = days_in_month(m, y);
        if (len == '0 || d == '0 || d > len) begin
          res.bad_date = 1'b1;
        end else begin
          cur_day = d;
          cur_month = m;
          cur_year = y;
        end
      end
      CMD_INC: begin
        len = days_in_month(cur_month, cur_year);
        if (cur_day < len) begin
          cur_day = cur_day + 5'd1;
        end else if (cur_month >= MonthLast) begin
          if (cur_year == YearMax) begin
            res.bad_date = 1'b1;
          end else begin
            cur_year = cur_year + 16'd1;
            cur_month = 4'd1;
            cur_day = 5'd1;
          end
        end else begin
          cur_month = cur_month + 4'd1;
          cur_day = 5'd1;
        end
      end
      CMD_DEC: begin
        if (cur_day > 5'd1) begin
          cur_day = cur_day - 5'd1;
        end else if (cur_month <= 4'd1) begin
          if (cur_year == '0) begin
            res.bad_date = 1'b1;
          end else begin
            cur_year = cur_year - 16'd1;
            cur_month = MonthLast;
            cur_day = DayLast;
          end
        end else begin
          cur_month = cur_month - 4'd1;
          cur_day = days_in_month(cur_month, cur_year);
        end
      end
      default: begin
        if (cur_year != y)
          res.is_earlier = cur_year < y;
        else if (cur_month != m)
          res.is_earlier = cur_month < m;
        else
          res.is_earlier = cur_day < d;
      end
    endcase
    res.out_day = cur_day;
    res.out_month = cur_month;
    res.out_year = cur_year;
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [YearW-1:0] pick_year();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'($urandom_range(1, 4));
      2:       return 16'($urandom_range(65531, 65535));
      3, 4:    return 16'($urandom);
      default: return 16'($urandom_range(1896, 2104));
    endcase
  endfunction

  task automatic queue_cmd(cmd_t c, logic [DayW-1:0] d, logic [MonthW-1:0] m,
                           logic [YearW-1:0] y);
    in_item_t item;
    item.command = c;
    item.in_day = d;
    item.in_month = m;
    item.in_year = y;
    pending_cmds.push_back(item);
    items_queued++;
  endtask

  // A run of steps and compares from a date near a month start or end, or a single loose command.
  task automatic queue_sequence(ref int count);
    int unsigned r;
    int unsigned n;
    logic [MonthW-1:0] m;
    logic [YearW-1:0]  y;
    logic [DayW-1:0]   len;
    bit fwd;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      m = 4'($urandom_range(1, 12));
      y = pick_year();
      if (y == '0) y = 16'd1;
      len = days_in_month(m, y);
      if ($urandom_range(0, 1))
        queue_cmd(CMD_LOAD, len - 5'($urandom_range(0, 2)), m, y);
      else
        queue_cmd(CMD_LOAD, 5'($urandom_range(1, 3)), m, y);
      n = $urandom_range(1, 40);
      fwd = $urandom_range(0, 1);
      count += n + 1;
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          queue_cmd(CMD_CMP, 5'($urandom), $urandom_range(0, 3) == 0 ? '0 : m, y);
        else if (r < 22)
          queue_cmd(fwd ? CMD_DEC : CMD_INC, 5'($urandom), 4'($urandom), 16'($urandom));
        else
          queue_cmd(fwd ? CMD_INC : CMD_DEC, 5'($urandom), 4'($urandom), 16'($urandom));
      end
    end else begin
      count++;
      if (r < 75)
        queue_cmd(CMD_LOAD, 5'($urandom), 4'($urandom), pick_year());
      else if (r < 88)
        queue_cmd(CMD_CMP, 5'($urandom), 4'($urandom), pick_year());
      else
        queue_cmd(cmd_t'($urandom_range(0, 3)), 5'($urandom), 4'($urandom),
                  16'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (results_seen < items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Driver: hold the item while stalled, otherwise gap or send the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
        send_gap = quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on acceptance; track default writes.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_dates.push_back(date_after_command(in_data));
      case (in_data.command)
        CMD_LOAD: n_load++;
        CMD_INC:  n_inc++;
        CMD_DEC:  n_dec++;
        default:  n_cmp++;
      endcase
    end
    if (!rst && cfg_valid && cfg_ready) begin
      cfg_writes++;
      case (cfg_index)
        CFG_DEFAULT_DAY:   dflt_day = cfg_data[DayW-1:0];
        CFG_DEFAULT_MONTH: dflt_month = cfg_data[MonthW-1:0];
        CFG_DEFAULT_YEAR:  dflt_year = cfg_data[YearW-1:0];
        default: ;
      endcase
    end
  end

  // Result side: random stalls, then check against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.bad_date === 1'b1) n_bad++;
        if (out_data.is_earlier === 1'b1) n_earlier++;
        if (expected_dates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing expected: %0d/%0d/%0d bad=%b earlier=%b",
                     out_data.out_day, out_data.out_month, out_data.out_year,
                     out_data.bad_date, out_data.is_earlier);
        end else begin
          want = expected_dates.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at result %0d: want %0d/%0d/%0d bad=%b earlier=%b",
                       results_seen, want.out_day, want.out_month, want.out_year,
                       want.bad_date, want.is_earlier);
              $display("  got %0d/%0d/%0d bad=%b earlier=%b", out_data.out_day,
                       out_data.out_month, out_data.out_year, out_data.bad_date,
                       out_data.is_earlier);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = quiet ? 0 : pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d results", cycle_count,
               results_seen, items_queued);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [DayW-1:0]   nd;
    logic [MonthW-1:0] nm;
    logic [YearW-1:0]  ny;
    int count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // leap days, month lengths, bad months, boundaries and compares
    queue_cmd(CMD_CMP, 5'd0, 4'd0, 16'd0);
    queue_cmd(CMD_LOAD, 5'd29, 4'd2, 16'd2024);
    queue_cmd(CMD_LOAD, 5'd29, 4'd2, 16'd2023);
    queue_cmd(CMD_LOAD, 5'd30, 4'd2, 16'd2024);
    queue_cmd(CMD_LOAD, 5'd31, 4'd4, 16'd2021);
    queue_cmd(CMD_LOAD, 5'd5, 4'd13, 16'd2021);
    queue_cmd(CMD_LOAD, 5'd31, 4'd15, 16'd65535);
    queue_cmd(CMD_LOAD, 5'd1, 4'd3, 16'd2024);
    queue_cmd(CMD_DEC, 5'd0, 4'd0, 16'd0);
    queue_cmd(CMD_LOAD, 5'd1, 4'd3, 16'd2023);
    queue_cmd(CMD_DEC, 5'd31, 4'd15, 16'd65535);
    queue_cmd(CMD_INC, 5'd0, 4'd0, 16'd0);
    queue_cmd(CMD_LOAD, 5'd1, 4'd2, 16'd2023);
    queue_cmd(CMD_DEC, 5'd0, 4'd0, 16'd0);
    queue_cmd(CMD_INC, 5'd31, 4'd15, 16'd65535);
    queue_cmd(CMD_LOAD, 5'd31, 4'd12, 16'd65535);
    queue_cmd(CMD_INC, 5'd0, 4'd0, 16'd0);
    queue_cmd(CMD_DEC, 5'd0, 4'd0, 16'd0);
    queue_cmd(CMD_CMP, 5'd31, 4'd12, 16'd65535);
    queue_cmd(CMD_CMP, 5'd30, 4'd12, 16'd65535);
    queue_cmd(CMD_CMP, 5'd1, 4'd1, 16'd1);
    queue_cmd(CMD_CMP, 5'd31, 4'd15, 16'd65535);
    queue_cmd(CMD_LOAD, 5'd0, 4'd0, 16'd0);
    queue_cmd(CMD_LOAD, 5'd0, 4'd6, 16'd0);
    queue_cmd(CMD_LOAD, 5'd31, 4'd12, 16'd1999);
    queue_cmd(CMD_INC, 5'd0, 4'd0, 16'd0);
    wait_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin nd = 5'd31; nm = 4'd12; ny = YearMax; end
        1: begin nd = 5'd1;  nm = 4'd1;  ny = 16'd0;   end
        2: begin nd = 5'd0;  nm = 4'd0;  ny = 16'd2024; end
        3: begin nd = 5'd29; nm = 4'd2;  ny = 16'd2023; end
        4: begin
          nd = 5'($urandom_range(1, 31));
          nm = 4'($urandom_range(13, 15));
          ny = 16'($urandom);
        end
        5: begin
          nd = 5'($urandom_range(1, 31));
          nm = 4'($urandom_range(1, 12));
          ny = 16'($urandom);
        end
        default: begin nd = DayReset; nm = MonthReset; ny = YearReset; end
      endcase
      quiet = (p == 1);
      // spare upper data bits carry noise
      write_reg(CFG_DEFAULT_DAY, {11'($urandom), nd});
      write_reg(CFG_DEFAULT_MONTH, {12'($urandom), nm});
      write_reg(CFG_DEFAULT_YEAR, ny);

      // defaults alone, then steps both ways (year ends in the first two phases)
      queue_cmd(CMD_LOAD, 5'd0, 4'd0, 16'd0);
      queue_cmd(CMD_INC, 5'd0, 4'd0, 16'd0);
      queue_cmd(CMD_DEC, 5'd0, 4'd0, 16'd0);
      queue_cmd(CMD_DEC, 5'd0, 4'd0, 16'd0);
      queue_cmd(CMD_CMP, 5'd0, 4'd0, 16'd0);

      count = 0;
      while (count < PhaseItems / 2) queue_sequence(count);
      // hold the sender until the block has drained
      wait_idle();
      while (count < PhaseItems) queue_sequence(count);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (expected_dates.size() != 0) mismatches++;
    $display("ran %0d items: %0d loads, %0d increments, %0d decrements, %0d compares",
             items_queued, n_load, n_inc, n_dec, n_cmp);
    $display("%0d default writes; bad_date seen %0d times, is_earlier %0d; %0d mismatches",
             cfg_writes, n_bad, n_earlier, mismatches);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cdc_pkg.sv
hdl/cdc_step.sv
hdl/calendar_date_up_down_counter.sv
sim/testbench.sv
